// ===== rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define LRC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lrc assertion failed");

// checked at every edge, reset included
`define LRC_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) else $error("lrc assertion failed");

`endif

// ===== rtl/lrc_pkg.sv =====
package lrc_pkg;

  localparam int ADDR_W      = 10;
  localparam int DATA_W      = 32;
  localparam int OP_W        = 2;
  localparam int LVL_W       = 3;
  localparam int CNT_W       = 32;
  localparam int NUM_LEVELS  = 3;
  localparam int NUM_CNT     = 8;
  localparam int BLOCK_SHIFT = 2;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;

  localparam logic [1:0] ST_ADD = 2'd0;
  localparam logic [1:0] ST_SUB = 2'd1;
  localparam logic [1:0] ST_IGN = 2'd2;

  localparam logic [LVL_W-1:0] LV_L1   = 3'd0;
  localparam logic [LVL_W-1:0] LV_RAM  = 3'd3;
  localparam logic [LVL_W-1:0] LV_MISS = 3'd4;

  localparam int CNT_MEM_HIT  = 6;
  localparam int CNT_MEM_MISS = 7;

  localparam logic [DATA_W-1:0] EMPTY_WORD = '1;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag;
    logic [DATA_W-1:0] data;
  } lrc_entry_t;

  localparam int ENTRY_W = $bits(lrc_entry_t);

  // update request from the sequencer to one cache level
  typedef struct packed {
    logic              promote;
    logic              fill;
    logic [DATA_W-1:0] fill_data;
  } lrc_lvl_ctrl_t;

  // lookup outcome of one cache level
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
  } lrc_lvl_stat_t;

endpackage

// ===== rtl/lrc_in_if.sv =====
interface lrc_in_if import lrc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ADDR_W-1:0] address_a;
  logic [ADDR_W-1:0] address_b;
  logic [ADDR_W-1:0] address_dest;

  modport source (output valid, opcode, address_a, address_b, address_dest, input ready);
  modport sink   (input valid, opcode, address_a, address_b, address_dest, output ready);
endinterface

// ===== rtl/lrc_out_if.sv =====
interface lrc_out_if import lrc_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] result_value;
  logic [LVL_W-1:0]         level_a;
  logic [LVL_W-1:0]         level_b;
  logic [CNT_W-1:0]         l1_hit_count;
  logic [CNT_W-1:0]         l1_miss_count;
  logic [CNT_W-1:0]         l2_hit_count;
  logic [CNT_W-1:0]         l2_miss_count;
  logic [CNT_W-1:0]         l3_hit_count;
  logic [CNT_W-1:0]         l3_miss_count;
  logic [CNT_W-1:0]         mem_hit_count;
  logic [CNT_W-1:0]         mem_miss_count;

  modport source (output valid, status, result_value, level_a, level_b,
                  l1_hit_count, l1_miss_count, l2_hit_count, l2_miss_count,
                  l3_hit_count, l3_miss_count, mem_hit_count, mem_miss_count,
                  input ready);
  modport sink   (input valid, status, result_value, level_a, level_b,
                  l1_hit_count, l1_miss_count, l2_hit_count, l2_miss_count,
                  l3_hit_count, l3_miss_count, mem_hit_count, mem_miss_count,
                  output ready);
endinterface

// ===== rtl/lrc_ram.sv =====
module lrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lrc_level.sv =====
module lrc_level import lrc_pkg::*; #(
  parameter int SET_COUNT = 16,
  parameter int WAY_COUNT = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ADDR_W-1:0] addr,
  input  lrc_lvl_ctrl_t     ctrl,
  output lrc_lvl_stat_t     stat
);

  localparam int SET_AW = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int WAY_AW = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int ROW_W  = WAY_COUNT * ENTRY_W;

  typedef lrc_entry_t [WAY_COUNT-1:0] row_t;

  logic [SET_AW-1:0]    set;
  logic [SET_COUNT-1:0] row_valid_r;
  logic [ROW_W-1:0]     rd_row;
  logic [ROW_W-1:0]     wr_row;
  row_t                 row;
  row_t                 new_row;
  logic                 hit;
  logic [WAY_AW-1:0]    hit_pos;
  logic                 free_found;
  logic [WAY_AW-1:0]    free_pos;
  logic [WAY_AW-1:0]    pos;
  lrc_entry_t           ent;
  logic                 wr_en;

  assign set   = SET_AW'(32'(addr >> BLOCK_SHIFT) % SET_COUNT);
  assign wr_en = ctrl.promote | ctrl.fill;

  // one row per set, ways in recency order
  lrc_ram #(.WIDTH(ROW_W), .DEPTH(SET_COUNT)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (set),
    .wdata (wr_row),
    .raddr (set),
    .rdata (rd_row)
  );

  // a set never written reads as all ways invalid
  assign row    = row_valid_r[set] ? row_t'(rd_row) : row_t'('0);
  assign wr_row = ROW_W'(new_row);

  // tag match and first free way
  always_comb begin
    hit        = 1'b0;
    hit_pos    = '0;
    free_found = 1'b0;
    free_pos   = WAY_AW'(WAY_COUNT - 1);
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!hit && row[w].valid && row[w].tag == addr) begin
        hit     = 1'b1;
        hit_pos = WAY_AW'(w);
      end
      if (!free_found && !row[w].valid) begin
        free_found = 1'b1;
        free_pos   = WAY_AW'(w);
      end
    end
  end

  // move the chosen entry to the front, shifting the younger ones down
  always_comb begin
    pos = ctrl.fill ? free_pos : hit_pos;
    if (ctrl.fill) begin
      ent = '{valid: 1'b1, tag: addr, data: ctrl.fill_data};
    end else begin
      ent = row[hit_pos];
    end
    new_row[0] = ent;
    for (int w = 1; w < WAY_COUNT; w++) begin
      if (WAY_AW'(w) <= pos) begin
        new_row[w] = row[w-1];
      end else begin
        new_row[w] = row[w];
      end
    end
  end

  assign stat.hit  = hit;
  assign stat.data = row[hit_pos].data;

  // per-set valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[set] <= 1'b1;
    end
  end

endmodule

// ===== rtl/three_level_lru_cache_with_alu_top.sv =====
// Three-level LRU cache hierarchy with a word RAM and an add/subtract unit.
// in_ch carries one instruction (opcode, address_a, address_b, address_dest);
// out_ch returns status, the result, the level each operand came from and
// the eight hit/miss counters as they stand after that instruction.
// Each operand fetch reads one row of every cache level and the RAM word in
// parallel, then resolves hits, promotions and fills in the next cycle.
// After the input transfer the sequencer steps through read A, resolve A,
// read B, resolve B and execute; the result then enters the output register.
// The next instruction can be taken the cycle after, in idle; none is taken
// before the last one has left execute. The pace is set by the registered read
// of the set memories, each of which is read twice.
// After reset the RAM is swept to all ones, one word a cycle, through all MEM_WORDS
// words; in_ch.ready stays low meanwhile. Cache sets start invalid at once.
// The result sits in an output register; a new instruction is still taken
// while it waits, and the next result waits in execute until out_ch.ready.
`include "assert_macros.svh"

module three_level_lru_cache_with_alu_top import lrc_pkg::*; #(
  parameter int SET_COUNT = 16,
  parameter int WAY_COUNT = 4,
  parameter int MEM_WORDS = 1024
) (
  input logic       clk,
  input logic       rst_n,
  lrc_in_if.sink    in_ch,
  lrc_out_if.source out_ch
);

  localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_RD_A, S_EV_A, S_RD_B, S_EV_B, S_EXE
  } state_t;

  state_t            state_r;
  logic [MEM_AW-1:0] clr_idx_r;
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_a_r;
  logic [ADDR_W-1:0] addr_b_r;
  logic [ADDR_W-1:0] dest_r;
  logic [DATA_W-1:0] val_a_r;
  logic [DATA_W-1:0] val_b_r;
  logic [LVL_W-1:0]  lvl_a_r;
  logic [LVL_W-1:0]  lvl_b_r;
  logic [CNT_W-1:0]  cnt_r [NUM_CNT];

  logic              out_valid_r;
  logic [1:0]        status_r;
  logic [DATA_W-1:0] result_r;
  logic [LVL_W-1:0]  out_lvl_a_r;
  logic [LVL_W-1:0]  out_lvl_b_r;
  logic [CNT_W-1:0]  out_cnt_r [NUM_CNT];

  logic [ADDR_W-1:0] cur_addr;
  lrc_lvl_ctrl_t     lvl_ctrl [NUM_LEVELS];
  lrc_lvl_stat_t     lvl_stat [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] hit_vec;
  logic [NUM_LEVELS-1:0] promote;
  logic [NUM_LEVELS-1:0] fill;
  logic [NUM_CNT-1:0]    bump;
  logic              ev_en;
  logic              found;
  logic              up;
  logic [DATA_W-1:0] ev_val;
  logic [LVL_W-1:0]  ev_lvl;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [MEM_AW-1:0] ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic              exe_go;
  logic [1:0]        exe_status;
  logic [DATA_W-1:0] exe_result;

  assign in_ch.ready = (state_r == S_IDLE);
  assign cur_addr    = (state_r == S_RD_B || state_r == S_EV_B) ? addr_b_r : addr_a_r;
  assign ev_en       = (state_r == S_EV_A || state_r == S_EV_B);
  assign exe_go      = (state_r == S_EXE) && (!out_valid_r || out_ch.ready);

  // cache levels
  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_lvl
    lrc_level #(.SET_COUNT(SET_COUNT), .WAY_COUNT(WAY_COUNT)) u_level (
      .clk   (clk),
      .rst_n (rst_n),
      .addr  (cur_addr),
      .ctrl  (lvl_ctrl[g]),
      .stat  (lvl_stat[g])
    );
    assign hit_vec[g]            = lvl_stat[g].hit;
    assign lvl_ctrl[g].promote   = ev_en & promote[g];
    assign lvl_ctrl[g].fill      = ev_en & fill[g];
    assign lvl_ctrl[g].fill_data = ev_val;
  end

  // backing ram, swept to all ones after reset
  assign ram_raddr = MEM_AW'(32'(cur_addr) % MEM_WORDS);
  assign ram_we    = (state_r == S_CLR) || (exe_go && exe_status != ST_IGN);
  assign ram_waddr = (state_r == S_CLR) ? clr_idx_r : MEM_AW'(32'(dest_r) % MEM_WORDS);
  assign ram_wdata = (state_r == S_CLR) ? EMPTY_WORD : exe_result;

  lrc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // resolve one operand: first hitting level, fills above it, counter bumps
  always_comb begin
    found   = 1'b0;
    ev_val  = EMPTY_WORD;
    ev_lvl  = LV_MISS;
    promote = '0;
    fill    = '0;
    bump    = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (!found) begin
        if (hit_vec[i]) begin
          found       = 1'b1;
          promote[i]  = 1'b1;
          ev_val      = lvl_stat[i].data;
          ev_lvl      = LVL_W'(i);
          bump[2*i]   = 1'b1;
        end else begin
          bump[2*i+1] = 1'b1;
        end
      end
    end
    up = 1'b0;
    if (!found) begin
      if (ram_rdata != EMPTY_WORD) begin
        ev_val            = ram_rdata;
        ev_lvl            = LV_RAM;
        bump[CNT_MEM_HIT] = 1'b1;
        up                = 1'b1;
      end else begin
        bump[CNT_MEM_MISS] = 1'b1;
      end
    end
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      fill[i] = up;
      up      = up | promote[i];
    end
  end

  // alu
  always_comb begin
    case (op_r)
      OP_ADD: begin
        exe_status = ST_ADD;
        exe_result = val_a_r + val_b_r;
      end
      OP_SUB: begin
        exe_status = ST_SUB;
        exe_result = val_a_r - val_b_r;
      end
      default: begin
        exe_status = ST_IGN;
        exe_result = '0;
      end
    endcase
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_CNT; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      if (out_valid_r && out_ch.ready && !exe_go) begin
        out_valid_r <= 1'b0;
      end
      if (ev_en) begin
        for (int k = 0; k < NUM_CNT; k++) begin
          if (bump[k] && cnt_r[k] != '1) begin
            cnt_r[k] <= cnt_r[k] + 1'b1;
          end
        end
      end
      unique case (state_r)
        S_CLR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == MEM_AW'(MEM_WORDS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            op_r     <= in_ch.opcode;
            addr_a_r <= in_ch.address_a;
            addr_b_r <= in_ch.address_b;
            dest_r   <= in_ch.address_dest;
            state_r  <= S_RD_A;
          end
        end
        S_RD_A: state_r <= S_EV_A;
        S_EV_A: begin
          val_a_r <= ev_val;
          lvl_a_r <= ev_lvl;
          state_r <= S_RD_B;
        end
        S_RD_B: state_r <= S_EV_B;
        S_EV_B: begin
          val_b_r <= ev_val;
          lvl_b_r <= ev_lvl;
          state_r <= S_EXE;
        end
        S_EXE: begin
          if (exe_go) begin
            out_valid_r <= 1'b1;
            status_r    <= exe_status;
            result_r    <= exe_result;
            out_lvl_a_r <= lvl_a_r;
            out_lvl_b_r <= lvl_b_r;
            for (int k = 0; k < NUM_CNT; k++) begin
              out_cnt_r[k] <= cnt_r[k];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.result_value   = result_r;
  assign out_ch.level_a        = out_lvl_a_r;
  assign out_ch.level_b        = out_lvl_b_r;
  assign out_ch.l1_hit_count   = out_cnt_r[0];
  assign out_ch.l1_miss_count  = out_cnt_r[1];
  assign out_ch.l2_hit_count   = out_cnt_r[2];
  assign out_ch.l2_miss_count  = out_cnt_r[3];
  assign out_ch.l3_hit_count   = out_cnt_r[4];
  assign out_ch.l3_miss_count  = out_cnt_r[5];
  assign out_ch.mem_hit_count  = out_cnt_r[CNT_MEM_HIT];
  assign out_ch.mem_miss_count = out_cnt_r[CNT_MEM_MISS];

  // checks
  `LRC_ASSERT_ALWAYS(a_no_take_while_clearing, (state_r == S_CLR) |-> !in_ch.ready)
  `LRC_ASSERT(a_clear_once, (state_r != S_CLR) |=> (state_r != S_CLR))
  `LRC_ASSERT(a_single_promote, ev_en |-> $onehot0(promote))
  `LRC_ASSERT(a_fill_only_on_miss, ev_en |-> ((fill & hit_vec) == '0))

endmodule
